// ----- rtl/assert_macros.svh -----
// Assertion macros used by the port-level checker of the header builder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside of reset.
`define UHB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen on a rising clock edge outside of reset.
`define UHB_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- rtl/uhb_pkg.sv -----
// Types, constants and helper functions of the UDP/IPv4 header builder.
package uhb_pkg;

  localparam int MAX_PAYLOAD = 1472;
  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  localparam logic [1:0] REG_SOURCE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_DEST_ADDRESS = 2'd1;
  localparam logic [1:0] REG_SOURCE_PORT = 2'd2;
  localparam logic [1:0] REG_DEST_PORT = 2'd3;

  localparam logic [7:0] IPV4_VER_IHL = 8'h45;
  localparam logic [7:0] IPV4_TTL = 8'd64;
  localparam logic [7:0] UDP_PROTOCOL = 8'd17;
  localparam logic [15:0] UDP_HDR_BYTES = 16'd8;
  localparam logic [15:0] IP_UDP_HDR_BYTES = 16'd28;

  // Checksum steps run 0..SUM_LAST, header words 0..WORD_LAST.
  localparam logic [2:0] SUM_LAST = 3'd4;
  localparam logic [2:0] WORD_LAST = 3'd6;

  typedef struct packed {
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
  } cfg_t;

  // Everything the back end needs to know about one finished datagram.
  typedef struct packed {
    logic [15:0]      sum;
    logic [15:0]      pad_word;
    logic [LEN_W-1:0] len;
    logic             overflow;
  } desc_t;

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

// ----- rtl/uhb_front.sv -----
// Front end: counts payload bytes and accumulates the payload checksum.
module uhb_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          payload_byte,
  input  logic                end_of_payload,
  output logic                push,
  output uhb_pkg::desc_t      push_desc
);

  logic [15:0]              running_sum, running_sum_next;
  logic [7:0]               pending_high_byte, pending_high_byte_next;
  logic                     odd_byte_waiting, odd_byte_waiting_next;
  logic [uhb_pkg::LEN_W-1:0] payload_length, payload_length_next;
  logic                     overflow_seen, overflow_seen_next;

  always_comb begin
    running_sum_next = running_sum;
    pending_high_byte_next = pending_high_byte;
    odd_byte_waiting_next = odd_byte_waiting;
    payload_length_next = payload_length;
    overflow_seen_next = overflow_seen;
    if (payload_length < uhb_pkg::LEN_W'(uhb_pkg::MAX_PAYLOAD)) begin
      payload_length_next = payload_length + 1'b1;
      if (odd_byte_waiting) begin
        running_sum_next = uhb_pkg::oc_add(running_sum, {pending_high_byte, payload_byte});
        pending_high_byte_next = 8'd0;
        odd_byte_waiting_next = 1'b0;
      end else begin
        pending_high_byte_next = payload_byte;
        odd_byte_waiting_next = 1'b1;
      end
    end else begin
      overflow_seen_next = 1'b1;
    end
  end

  assign push = accept && end_of_payload;

  always_comb begin
    push_desc.sum = running_sum_next;
    push_desc.pad_word = odd_byte_waiting_next ? {pending_high_byte_next, 8'd0} : 16'd0;
    push_desc.len = payload_length_next;
    push_desc.overflow = overflow_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      running_sum <= '0;
      pending_high_byte <= '0;
      odd_byte_waiting <= 1'b0;
      payload_length <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      running_sum <= running_sum_next;
      pending_high_byte <= pending_high_byte_next;
      odd_byte_waiting <= odd_byte_waiting_next;
      payload_length <= payload_length_next;
      overflow_seen <= overflow_seen_next;
    end
  end

endmodule

// ----- rtl/uhb_queue.sv -----
// Short descriptor queue between the byte front end and the header back end.
module uhb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  uhb_pkg::desc_t push_desc,
  input  logic           pop,
  output logic           head_valid,
  output uhb_pkg::desc_t head_desc,
  output logic           full
);

  uhb_pkg::desc_t entries [uhb_pkg::QUEUE_DEPTH];
  logic [uhb_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [uhb_pkg::QCNT_W-1:0] count;

  assign head_valid = (count != '0);
  assign full = (count == uhb_pkg::QCNT_W'(uhb_pkg::QUEUE_DEPTH));
  assign head_desc = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/uhb_back.sv -----
// Back end: finishes the UDP checksum and sends the seven header words.
module uhb_back (
  input  logic           clk,
  input  logic           rst,
  input  uhb_pkg::cfg_t  cfg,
  input  logic           head_valid,
  input  uhb_pkg::desc_t head_desc,
  output logic           pop,
  output logic [31:0]    header_word,
  output logic           last_word,
  output logic           too_long,
  output logic           out_valid,
  input  logic           out_stall
);

  logic           busy;
  logic [2:0]     sum_step;
  logic           sum_done;
  logic [2:0]     word_idx;
  uhb_pkg::desc_t cur;
  logic [15:0]    csum;

  logic [15:0] udp_len, total_len, check, op_a, op_b;
  logic [31:0] word_sel;
  logic        out_free, emit, finish;

  assign udp_len = 16'(cur.len) + uhb_pkg::UDP_HDR_BYTES;
  assign total_len = 16'(cur.len) + uhb_pkg::IP_UDP_HDR_BYTES;
  // A checksum that comes out as zero is sent as all ones.
  assign check = (~csum == 16'd0) ? 16'hFFFF : ~csum;

  always_comb begin
    case (sum_step)
      3'd0: begin
        op_a = cur.pad_word;
        op_b = cfg.source_address[31:16];
      end
      3'd1: begin
        op_a = cfg.source_address[15:0];
        op_b = cfg.dest_address[31:16];
      end
      3'd2: begin
        op_a = cfg.dest_address[15:0];
        op_b = {8'd0, uhb_pkg::UDP_PROTOCOL};
      end
      3'd3: begin
        op_a = udp_len;
        op_b = cfg.source_port;
      end
      3'd4: begin
        op_a = cfg.dest_port;
        op_b = udp_len;
      end
      default: begin
        op_a = 16'd0;
        op_b = 16'd0;
      end
    endcase
  end

  always_comb begin
    case (word_idx)
      3'd0: word_sel = {uhb_pkg::IPV4_VER_IHL, 8'd0, total_len};
      3'd1: word_sel = 32'd0;
      3'd2: word_sel = {uhb_pkg::IPV4_TTL, uhb_pkg::UDP_PROTOCOL, 16'd0};
      3'd3: word_sel = cfg.source_address;
      3'd4: word_sel = cfg.dest_address;
      3'd5: word_sel = {cfg.source_port, cfg.dest_port};
      default: word_sel = {udp_len, check};
    endcase
  end

  assign out_free = !out_valid || !out_stall;
  // The last word waits for the checksum; the others go out right away.
  assign emit = busy && out_free && ((word_idx != uhb_pkg::WORD_LAST) || sum_done);
  assign finish = emit && (word_idx == uhb_pkg::WORD_LAST);
  assign pop = head_valid && (!busy || finish);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      sum_step <= '0;
      sum_done <= 1'b0;
      word_idx <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      sum_step <= '0;
      sum_done <= 1'b0;
      word_idx <= '0;
    end else begin
      if (finish) begin
        busy <= 1'b0;
      end
      if (busy && !sum_done) begin
        sum_step <= sum_step + 1'b1;
        if (sum_step == uhb_pkg::SUM_LAST) begin
          sum_done <= 1'b1;
        end
      end
      if (emit) begin
        word_idx <= word_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_desc;
      csum <= head_desc.sum;
    end else if (busy && !sum_done) begin
      csum <= uhb_pkg::oc_add(uhb_pkg::oc_add(csum, op_a), op_b);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      header_word <= word_sel;
      last_word <= (word_idx == uhb_pkg::WORD_LAST);
      too_long <= cur.overflow;
    end
  end

endmodule

// ----- rtl/udp_ipv4_header_builder.sv -----
// Top level of the UDP/IPv4 header builder: configuration registers and datapath.
//
// Input channel: one UDP payload byte per transfer (payload_byte), with
// end_of_payload set on the last byte of a datagram. Bytes are taken one per
// cycle; in_stall rises only while four finished datagrams wait for headers.
// Output channel: for each datagram, seven 32-bit header words in network
// order (five IPv4 words, then two UDP words); last_word marks the seventh,
// and too_long is set on all seven if bytes beyond the maximum were dropped.
// After the last byte's transfer, its descriptor is written into the queue,
// then loaded into the header engine, and the first word is then registered
// onto the output. With the receiver never stalling, headers go out back to
// back, one word per cycle; the next datagram loads in the cycle of the
// previous last word. The UDP checksum is completed by a ones-complement
// adder chain that adds two 16-bit terms per cycle, hidden behind the first
// six words.
// When the receiver stalls, the output word holds and the header engine
// waits; incoming bytes keep flowing until the datagram queue fills.
// Reset clears the configuration registers, the running byte count and
// checksum, the queue and the output valid. The user must write configuration via
// cfg_write, cfg_index and cfg_data while idle; the block does not enforce this.
module udp_ipv4_header_builder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  payload_byte,
  input  logic        end_of_payload,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] header_word,
  output logic        last_word,
  output logic        too_long,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  uhb_pkg::cfg_t  cfg;
  uhb_pkg::desc_t push_desc, head_desc;
  logic           push, pop, head_valid, full, accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        uhb_pkg::REG_SOURCE_ADDRESS: cfg.source_address <= cfg_data;
        uhb_pkg::REG_DEST_ADDRESS: cfg.dest_address <= cfg_data;
        uhb_pkg::REG_SOURCE_PORT: cfg.source_port <= cfg_data[15:0];
        uhb_pkg::REG_DEST_PORT: cfg.dest_port <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign in_stall = full;
  assign accept = in_valid && !in_stall;

  uhb_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .payload_byte   (payload_byte),
    .end_of_payload (end_of_payload),
    .push           (push),
    .push_desc      (push_desc)
  );

  uhb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .pop        (pop),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .full       (full)
  );

  uhb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head_valid  (head_valid),
    .head_desc   (head_desc),
    .pop         (pop),
    .header_word (header_word),
    .last_word   (last_word),
    .too_long    (too_long),
    .out_valid   (out_valid),
    .out_stall   (out_stall)
  );

endmodule

// ----- rtl/uhb_checker.sv -----
// Port-level checks of the header builder, bound to its top level.
`include "assert_macros.svh"

module uhb_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] header_word,
  input logic        last_word
);

  `UHB_ASSERT(a_valid_holds, out_valid && out_stall |=> out_valid, "output valid dropped while stalled")
  `UHB_ASSERT(a_word_holds, out_valid && out_stall |=> $stable(header_word), "stalled header word changed")
  `UHB_NEVER(a_zero_checksum, out_valid && last_word && (header_word[15:0] == 16'd0), "UDP checksum of zero sent")
  `UHB_NEVER(a_short_udp_len, out_valid && last_word && (header_word[31:16] < 16'd8), "UDP length below header size")

endmodule

bind udp_ipv4_header_builder uhb_checker u_uhb_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .header_word (header_word),
  .last_word   (last_word)
);

// ----- tb/header_checker.sv -----
// Checker for the UDP/IPv4 header builder: predicts header words and compares transfers.
`timescale 1ns / 100ps

module header_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  payload_byte,
  input  logic        end_of_payload,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] header_word,
  input  logic        last_word,
  input  logic        too_long,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          outstanding
);

  typedef struct {
    logic [31:0] word;
    logic        last;
    logic        trunc;
  } hdr_word_t;

  hdr_word_t expected_words[$];

  uhb_pkg::cfg_t             regs;
  logic [15:0]               payload_sum;
  logic [7:0]                high_byte;
  logic                      have_high;
  logic [uhb_pkg::LEN_W-1:0] byte_count;
  logic                      dropped;

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    t = {1'b0, t[15:0]} + {16'd0, t[16]};
    return t[15:0];
  endfunction

  task automatic clear_datagram();
    payload_sum = '0;
    high_byte = '0;
    have_high = 1'b0;
    byte_count = '0;
    dropped = 1'b0;
  endtask

  // Queues the seven header words for the datagram that just ended.
  task automatic emit_header();
    logic [15:0] udp_len;
    logic [15:0] total_len;
    logic [15:0] s;
    logic [15:0] chk;
    logic [31:0] w[7];
    udp_len = uhb_pkg::UDP_HDR_BYTES + 16'(byte_count);
    total_len = uhb_pkg::IP_UDP_HDR_BYTES + 16'(byte_count);
    s = payload_sum;
    if (have_high) s = ones_add(s, {high_byte, 8'h00});
    s = ones_add(s, regs.source_address[31:16]);
    s = ones_add(s, regs.source_address[15:0]);
    s = ones_add(s, regs.dest_address[31:16]);
    s = ones_add(s, regs.dest_address[15:0]);
    s = ones_add(s, {8'h00, uhb_pkg::UDP_PROTOCOL});
    s = ones_add(s, udp_len);
    s = ones_add(s, regs.source_port);
    s = ones_add(s, regs.dest_port);
    s = ones_add(s, udp_len);
    chk = ~s;
    // A zero checksum means "none" in UDP, so it goes out as all ones.
    if (chk == 16'h0000) chk = 16'hFFFF;
    w[0] = {uhb_pkg::IPV4_VER_IHL, 8'h00, total_len};
    w[1] = 32'h0000_0000;
    w[2] = {uhb_pkg::IPV4_TTL, uhb_pkg::UDP_PROTOCOL, 16'h0000};
    w[3] = regs.source_address;
    w[4] = regs.dest_address;
    w[5] = {regs.source_port, regs.dest_port};
    w[6] = {udp_len, chk};
    for (int k = 0; k < 7; k++) begin
      expected_words.push_back('{w[k], k == int'(uhb_pkg::WORD_LAST), dropped});
    end
  endtask

  always @(posedge clk) begin
    hdr_word_t e;
    if (rst) begin
      regs = '0;
      clear_datagram();
      expected_words.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected header transfer word=%h last=%b too_long=%b",
                     $realtime, header_word, last_word, too_long);
          mismatches++;
        end else begin
          e = expected_words.pop_front();
          if (e.word !== header_word || e.last !== last_word || e.trunc !== too_long) begin
            if (mismatches < 10)
              $display({"%0t: header mismatch: expected word=%h last=%b too_long=%b,",
                        " got word=%h last=%b too_long=%b"},
                       $realtime, e.word, e.last, e.trunc,
                       header_word, last_word, too_long);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (byte_count < uhb_pkg::MAX_PAYLOAD) begin
          byte_count++;
          if (have_high) begin
            payload_sum = ones_add(payload_sum, {high_byte, payload_byte});
            high_byte = '0;
            have_high = 1'b0;
          end else begin
            high_byte = payload_byte;
            have_high = 1'b1;
          end
        end else begin
          dropped = 1'b1;
        end
        if (end_of_payload) begin
          emit_header();
          clear_datagram();
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          uhb_pkg::REG_SOURCE_ADDRESS: regs.source_address = cfg_data;
          uhb_pkg::REG_DEST_ADDRESS:   regs.dest_address = cfg_data;
          uhb_pkg::REG_SOURCE_PORT:    regs.source_port = cfg_data[15:0];
          uhb_pkg::REG_DEST_PORT:      regs.dest_port = cfg_data[15:0];
          default: ;
        endcase
      end
    end
    outstanding = expected_words.size();
  end

endmodule

// ----- tb/testbench.sv -----
// Top of the header builder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;

  localparam int RANDOM_BYTES = 260;
  localparam int QUIET_AFTER = 200;
  localparam int LONG_HOLD = 150;
  localparam int FILL_DATAGRAMS = 8;
  localparam int SETTLE_CYCLES = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  payload_byte = 8'h00;
  logic        end_of_payload = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] header_word;
  logic        last_word;
  logic        too_long;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = uhb_pkg::REG_SOURCE_ADDRESS;
  logic [31:0] cfg_data = 32'h0000_0000;

  int mismatches;
  int outstanding;
  int bytes_sent = 0;
  bit in_idle_on = 1'b1;
  bit out_idle_on = 1'b1;
  bit hold_req = 1'b0;

  udp_ipv4_header_builder dut (.*);

  header_checker header_check (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver side: random stall bursts, and one long hold-off on request.
  initial begin : receiver
    int n;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        @(posedge clk);
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (out_idle_on && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 3);
        @(posedge clk);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eop);
    int gap;
    in_valid <= 1'b1;
    payload_byte <= b;
    end_of_payload <= eop;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (in_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_datagram(input int len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        default: b = 8'($urandom);
      endcase
      send_byte(b, i == len - 1);
      bytes_sent++;
    end
  endtask

  // Stops the input and waits for every header, plus time for the engine to go quiet.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [31:0] src, input logic [31:0] dst,
                              input logic [31:0] sport, input logic [31:0] dport);
    cfg_write <= 1'b1;
    cfg_index <= uhb_pkg::REG_SOURCE_ADDRESS;
    cfg_data <= src;
    @(posedge clk);
    cfg_index <= uhb_pkg::REG_DEST_ADDRESS;
    cfg_data <= dst;
    @(posedge clk);
    cfg_index <= uhb_pkg::REG_SOURCE_PORT;
    cfg_data <= sport;
    @(posedge clk);
    cfg_index <= uhb_pkg::REG_DEST_PORT;
    cfg_data <= dport;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin : stimulus
    int phase;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers still at reset: the first datagram's bytes and header terms sum
    // to all ones, so the computed checksum is zero.
    send_byte(8'hFF, 1'b0);
    send_byte(8'hDA, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b1);
    drain();

    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7F, 1'b1);
    drain();

    bytes_sent = 0;
    phase = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      drain();
      program_regs($urandom, $urandom, $urandom, $urandom);
      if (phase == 1) begin
        // Short datagrams against a held receiver fill the datagram queue.
        hold_req = 1'b1;
        repeat (FILL_DATAGRAMS) send_datagram($urandom_range(1, 3));
      end
      repeat (10) begin
        if (bytes_sent >= QUIET_AFTER) begin
          in_idle_on = 1'b0;
          out_idle_on = 1'b0;
        end
        if ($urandom_range(0, 7) == 0)
          send_datagram($urandom_range(9, 40));
        else
          send_datagram($urandom_range(1, 8));
      end
      phase++;
    end
    drain();

    @(negedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/uhb_pkg.sv
rtl/uhb_front.sv
rtl/uhb_queue.sv
rtl/uhb_back.sv
rtl/udp_ipv4_header_builder.sv
rtl/uhb_checker.sv
tb/header_checker.sv
tb/testbench.sv
